// ----- rtl/graph_cut_weight_and_flip_gain_macros.svh -----
// ----------------------------------------------------------------------------
// Graph cut engine assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef GRAPH_CUT_WEIGHT_AND_FLIP_GAIN_MACROS_SVH
`define GRAPH_CUT_WEIGHT_AND_FLIP_GAIN_MACROS_SVH

`ifndef ASSERT_OFF

// check prop on every rising clk edge outside reset
`define GCW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check prop on every rising clk edge, reset included
`define GCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GCW_ASSERT(lbl, clk, rstn, prop, msg)

`define GCW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/gcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Graph cut engine package
// Request codes and fixed field widths of the item and result beats.
// ----------------------------------------------------------------------------
package gcw_pkg;

	localparam int REQ_W    = 2;
	localparam int VERTEX_W = 10;
	localparam int WEIGHT_W = 16;
	localparam int BASE_W   = 32;
	localparam int VALUE_W  = 32;

	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_SET  = 2'd0;
	localparam req_t REQ_CUT  = 2'd1;
	localparam req_t REQ_GAIN = 2'd2;
	localparam req_t REQ_LOCK = 2'd3;

endpackage

// ----- rtl/graph_cut_weight_and_flip_gain.sv -----
// ----------------------------------------------------------------------------
// Graph cut weight and vertex flip gain engine
// Per-vertex side and lock bits in an on-chip memory; edge beats feed a
// saturating accumulator in cut, gain or locked-gain mode.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  --------  ---------------------------  ------------------------------------
//  item      item_valid / item_ready      req_type vertex side locked has_edge
//                                         edge_from edge_to weight base_score last
//  result    result_valid / result_ready  value saturated
//
// One item per cycle while item_ready is high; the result of a last item passes
// stage 1 and stage 2 into the result register, which raises result_valid.
// The rate is set by the two read ports of the vertex memory and the single
// accumulator add with clamp, both taken once per cycle.
// After reset a clearing pass writes every entry of the vertex memory to zero,
// with item_ready low.
// A stalled result holds the stages behind it only as far as they are full.
// ----------------------------------------------------------------------------
`include "graph_cut_weight_and_flip_gain_macros.svh"

module graph_cut_weight_and_flip_gain
	import gcw_pkg::*;
#(
	parameter int NUM_VERTICES = 1024,
	parameter int WEIGHT_BITS  = 16,
	parameter int ACC_BITS     = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [REQ_W-1:0]           req_type,
	input  logic [VERTEX_W-1:0]        vertex,
	input  logic                       side,
	input  logic                       locked,
	input  logic                       has_edge,
	input  logic [VERTEX_W-1:0]        edge_from,
	input  logic [VERTEX_W-1:0]        edge_to,
	input  logic signed [WEIGHT_W-1:0] weight,
	input  logic signed [BASE_W-1:0]   base_score,
	input  logic                       last,

	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [VALUE_W-1:0]  value,
	output logic                       saturated
);

	localparam int VA = $clog2(NUM_VERTICES);
	localparam int XW = (VA > VERTEX_W) ? VA : VERTEX_W;
	// wide enough for accumulator plus a negated weight or base score
	localparam int SW = ((ACC_BITS > BASE_W + 1) ? ACC_BITS : BASE_W + 1) + 1;

	localparam logic signed [SW-1:0] ACC_HI =
		{{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

	function automatic logic [SW:0] sat_add(input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b);
		logic signed [SW-1:0] s;
		s = a + b;
		if (s > ACC_HI) begin
			return {1'b1, ACC_HI};
		end else if (s < ACC_LO) begin
			return {1'b1, ACC_LO};
		end
		return {1'b0, s};
	endfunction

	// clearing pass
	logic          clear_q;
	logic [VA-1:0] clr_addr_q;

	// vertex memory: {side, lock}
	logic [1:0] mem_q [NUM_VERTICES];

	// stage 1: registered memory reads and item fields
	logic                         valid_s1;
	req_t                         req_s1;
	logic                         last_s1;
	logic                         edge_s1;
	logic signed [WEIGHT_BITS-1:0] w_s1;
	logic signed [BASE_W-1:0]     base_s1;
	logic                         far_to_s1;
	logic                         from_ok_s1;
	logic                         to_ok_s1;
	logic [1:0]                   rd_from_s1;
	logic [1:0]                   rd_to_s1;

	// accumulator
	logic signed [ACC_BITS-1:0] acc_q;
	logic                       sat_q;

	// stage 2: closed evaluation waiting for base score
	logic                 valid_s2;
	logic signed [SW-1:0] acc_s2;
	logic                 sat_s2;
	logic                 gain_s2;
	logic signed [BASE_W-1:0] base_s2;

	// result register
	logic                      result_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      saturated_q;

	// handshake and addressing
	logic                     item_accept;
	logic                     rdy_out;
	logic                     rdy_s2;
	logic                     move_s2;
	logic                     take_s1;
	logic                     close_s1;
	logic [XW-1:0]            v_ext;
	logic [XW-1:0]            f_ext;
	logic [XW-1:0]            t_ext;
	logic                     v_ok;
	logic [WEIGHT_BITS+WEIGHT_W-1:0] w_ext;

	// edge arithmetic
	logic                 side_f;
	logic                 side_t;
	logic                 lock_f;
	logic                 lock_t;
	logic                 cut;
	logic                 far_lock;
	logic signed [SW-1:0] wx;
	logic signed [SW-1:0] addend;
	logic [SW:0]          edge_r;
	logic [SW:0]          base_r;

	assign rdy_out     = !result_valid_q || result_ready;
	assign move_s2     = valid_s2 && rdy_out;
	assign rdy_s2      = !valid_s2 || rdy_out;
	assign take_s1     = valid_s1 && rdy_s2;
	assign close_s1    = take_s1 && (req_s1 != REQ_SET) && last_s1;
	assign item_ready  = !clear_q && (!valid_s1 || rdy_s2);
	assign item_accept = item_valid && item_ready;

	assign v_ext = XW'(vertex);
	assign f_ext = XW'(edge_from);
	assign t_ext = XW'(edge_to);
	assign v_ok  = 32'(vertex) < 32'(NUM_VERTICES);
	assign w_ext = {{WEIGHT_BITS{1'b0}}, weight};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + VA'(1);
			if (clr_addr_q == VA'(NUM_VERTICES - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (item_accept && req_type == REQ_SET && v_ok) begin
			mem_q[v_ext[VA-1:0]] <= {side, locked};
		end
		if (item_accept) begin
			rd_from_s1 <= mem_q[f_ext[VA-1:0]];
			rd_to_s1   <= mem_q[t_ext[VA-1:0]];
			from_ok_s1 <= 32'(edge_from) < 32'(NUM_VERTICES);
			to_ok_s1   <= 32'(edge_to) < 32'(NUM_VERTICES);
			far_to_s1  <= edge_from == vertex;
			req_s1     <= req_type;
			last_s1    <= last;
			edge_s1    <= has_edge;
			w_s1       <= w_ext[WEIGHT_BITS-1:0];
			base_s1    <= base_score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// out-of-range endpoints read as side 0, unlocked
	assign side_f   = rd_from_s1[1] & from_ok_s1;
	assign lock_f   = rd_from_s1[0] & from_ok_s1;
	assign side_t   = rd_to_s1[1] & to_ok_s1;
	assign lock_t   = rd_to_s1[0] & to_ok_s1;
	assign cut      = side_f ^ side_t;
	assign far_lock = far_to_s1 ? lock_t : lock_f;
	assign wx       = SW'(w_s1);

	always_comb begin
		addend = '0;
		if (edge_s1) begin
			case (req_s1)
				REQ_CUT: begin
					addend = cut ? wx : '0;
				end
				REQ_GAIN: begin
					addend = cut ? -wx : wx;
				end
				REQ_LOCK: begin
					if (far_lock) begin
						addend = cut ? -wx : wx;
					end
				end
				default: begin
					addend = '0;
				end
			endcase
		end
	end

	assign edge_r = sat_add(SW'(acc_q), addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (take_s1 && req_s1 != REQ_SET) begin
			if (last_s1) begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end else begin
				acc_q <= edge_r[ACC_BITS-1:0];
				sat_q <= sat_q | edge_r[SW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (close_s1) begin
			valid_s2 <= 1'b1;
		end else if (move_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close_s1) begin
			acc_s2  <= edge_r[SW-1:0];
			sat_s2  <= sat_q | edge_r[SW];
			gain_s2 <= req_s1 == REQ_GAIN;
			base_s2 <= base_s1;
		end
	end

	// base score closes a gain evaluation with its own clamp
	assign base_r = sat_add(acc_s2, gain_s2 ? SW'(base_s2) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move_s2) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			value_q     <= base_r[VALUE_W-1:0];
			saturated_q <= sat_s2 | base_r[SW];
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign saturated    = saturated_q;

	`GCW_ASSERT(a_acc_cleared, clk, arst_n, close_s1 |=> (acc_q == '0 && !sat_q), "acc not cleared")
	`GCW_ASSERT(a_no_take_clear, clk, arst_n, clear_q |-> !item_accept, "beat taken in clear")
	`GCW_ASSERT(a_result_src, clk, arst_n, $rose(result_valid_q) |-> $past(valid_s2), "orphan result")
	`GCW_ASSERT(a_s2_hold, clk, arst_n, (valid_s2 && !rdy_out) |=> valid_s2, "stage 2 dropped")

endmodule
